/* sv/kss_pkg.sv */
// kss_pkg: shared types and constants for the kmp substring search block
// no dependencies
`default_nettype none

package kss_pkg;

   localparam int DATA_W = 8;
   localparam int POS_W  = 16;

   // request kinds carried in tuser bit 0
   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_TEXT    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEED,
      ST_WALK
   } kss_state_type;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [POS_W-1:0] start;
   } kss_result_type;

endpackage

`default_nettype wire

/* sv/kss_tables.sv */
// kss_tables: pattern byte memory and prefix-function memory
// one write port and one registered read port each; depends on kss_pkg
`default_nettype none

module kss_tables #(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [IW-1:0]             wr_addr,
   input  wire logic [kss_pkg::DATA_W-1:0] wr_byte,
   input  wire logic [IW-1:0]             wr_prefix,
   input  wire logic [IW-1:0]             st_rd_addr,
   input  wire logic [IW-1:0]             pf_rd_addr,
   output logic      [kss_pkg::DATA_W-1:0] st_rd_data,
   output logic      [IW-1:0]             pf_rd_data
);
   import kss_pkg::*;

   logic [DATA_W-1:0] st_mem [DEPTH];
   logic [IW-1:0]     pf_mem [DEPTH];
   logic [DATA_W-1:0] st_rd_ff;
   logic [IW-1:0]     pf_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         st_mem[wr_addr] <= wr_byte;
         pf_mem[wr_addr] <= wr_prefix;
      end
      st_rd_ff <= st_mem[st_rd_addr];
      pf_rd_ff <= pf_mem[pf_rd_addr];
   end

   assign st_rd_data = st_rd_ff;
   assign pf_rd_data = pf_rd_ff;

endmodule

`default_nettype wire

/* sv/kss_ctrl.sv */
// kss_ctrl: sequencer for pattern loading and text matching
// walks the prefix-function memory one fallback per cycle; depends on kss_pkg
`default_nettype none

module kss_ctrl #(
   parameter int              PATTERN_MAX = 16,
   parameter longint unsigned TEXT_MAX    = 65536,
   parameter int              IW          = 4,
   parameter int              LW          = 5
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_opcode,
   input  wire logic                       req_first,
   input  wire logic                       req_last,
   input  wire logic [kss_pkg::DATA_W-1:0] req_data,
   input  wire logic                       out_free,
   output kss_pkg::kss_result_type         res,
   output logic                            wr_en,
   output logic      [IW-1:0]              wr_addr,
   output logic      [kss_pkg::DATA_W-1:0] wr_byte,
   output logic      [IW-1:0]              wr_prefix,
   output logic      [IW-1:0]              st_rd_addr,
   output logic      [IW-1:0]              pf_rd_addr,
   input  wire logic [kss_pkg::DATA_W-1:0] st_rd_data,
   input  wire logic [IW-1:0]              pf_rd_data
);
   import kss_pkg::*;

   localparam longint unsigned LIMIT_RAW = TEXT_MAX - 64'd1;
   localparam logic [POS_W-1:0] POS_LIMIT =
      (LIMIT_RAW > 64'd65535) ? 16'hFFFF : POS_W'(LIMIT_RAW);
   localparam logic [LW-1:0] PLEN_MAX = LW'(PATTERN_MAX);

   kss_state_type     state_ff, state_in;
   logic              text_ff, text_in;
   logic              last_ff, last_in;
   logic [DATA_W-1:0] c_ff, c_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  text_pos_ff, text_pos_in;
   logic [LW-1:0]     m_ff, m_in;
   logic [LW-1:0]     plen_ff, plen_in;
   logic [LW-1:0]     matched_ff, matched_in;
   logic              done_ff, done_in;

   logic [LW-1:0]     plen_new, eff_m, m0, m_next, m_dec;
   logic [POS_W-1:0]  eff_pos, back;
   logic              eff_done, hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         plen_ff     <= '0;
         matched_ff  <= '0;
         text_pos_ff <= '0;
         done_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         plen_ff     <= plen_in;
         matched_ff  <= matched_in;
         text_pos_ff <= text_pos_in;
         done_ff     <= done_in;
      end
      text_ff <= text_in;
      last_ff <= last_in;
      c_ff    <= c_in;
      pos_ff  <= pos_in;
      m_ff    <= m_in;
   end

   always_comb begin
      state_in    = state_ff;
      text_in     = text_ff;
      last_in     = last_ff;
      c_in        = c_ff;
      pos_in      = pos_ff;
      text_pos_in = text_pos_ff;
      m_in        = m_ff;
      plen_in     = plen_ff;
      matched_in  = matched_ff;
      done_in     = done_ff;

      req_ready  = 1'b0;
      res        = '0;
      wr_en      = 1'b0;
      wr_addr    = plen_ff[IW-1:0];
      wr_byte    = c_ff;
      wr_prefix  = '0;
      m_dec      = m_ff - LW'(1);
      st_rd_addr = m_ff[IW-1:0];
      pf_rd_addr = m_dec[IW-1:0];

      plen_new = req_first ? '0 : plen_ff;
      eff_m    = req_first ? '0 : matched_ff;
      eff_pos  = req_first ? '0 : text_pos_ff;
      eff_done = req_first ? 1'b0 : done_ff;
      m0       = (eff_m >= plen_ff) ? '0 : eff_m;
      hit      = (st_rd_data == c_ff);
      m_next   = m_ff + LW'(hit);
      back     = POS_W'(plen_ff) - POS_W'(1);

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               c_in    = req_data;
               last_in = req_last;
               text_in = (req_opcode == OP_TEXT);
               if (req_opcode == OP_PATTERN) begin
                  matched_in  = '0;
                  text_pos_in = '0;
                  done_in     = 1'b0;
                  plen_in     = plen_new;
                  if (plen_new < PLEN_MAX) begin
                     if (plen_new == '0) begin
                        wr_en     = 1'b1;
                        wr_addr   = '0;
                        wr_byte   = req_data;
                        wr_prefix = '0;
                        plen_in   = LW'(1);
                     end else begin
                        m_dec      = plen_new - LW'(1);
                        pf_rd_addr = m_dec[IW-1:0];
                        state_in   = ST_SEED;
                     end
                  end
               end else begin
                  matched_in  = eff_m;
                  text_pos_in = eff_pos;
                  done_in     = eff_done;
                  if (!eff_done) begin
                     pos_in      = eff_pos;
                     text_pos_in = (eff_pos < POS_LIMIT) ? eff_pos + POS_W'(1) : eff_pos;
                     m_in        = m0;
                     m_dec       = m0 - LW'(1);
                     st_rd_addr  = m0[IW-1:0];
                     pf_rd_addr  = m_dec[IW-1:0];
                     state_in    = ST_WALK;
                  end
               end
            end
         end
         ST_SEED: begin
            m_in       = LW'(pf_rd_data);
            st_rd_addr = pf_rd_data;
            pf_rd_addr = pf_rd_data - IW'(1);
            state_in   = ST_WALK;
         end
         ST_WALK: begin
            if (text_ff && plen_ff == '0) begin
               // empty pattern matches at the start of the text
               if (out_free) begin
                  res.valid = 1'b1;
                  res.found = 1'b1;
                  res.start = '0;
                  done_in   = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else if (m_ff != '0 && !hit) begin
               m_in       = LW'(pf_rd_data);
               st_rd_addr = pf_rd_data;
               pf_rd_addr = pf_rd_data - IW'(1);
            end else if (!text_ff) begin
               wr_en     = 1'b1;
               wr_addr   = plen_ff[IW-1:0];
               wr_byte   = c_ff;
               wr_prefix = m_next[IW-1:0];
               plen_in   = plen_ff + LW'(1);
               state_in  = ST_IDLE;
            end else if (m_next == plen_ff) begin
               if (out_free) begin
                  res.valid  = 1'b1;
                  res.found  = 1'b1;
                  res.start  = (pos_ff >= back) ? pos_ff - back : '0;
                  matched_in = m_next;
                  done_in    = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else if (last_ff) begin
               if (out_free) begin
                  res.valid  = 1'b1;
                  matched_in = m_next;
                  done_in    = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               matched_in = m_next;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/kmp_substring_search_top.sv */
// kmp_substring_search_top: streaming first-occurrence substring search
// instantiates kss_tables and kss_ctrl, holds the result register; depends on kss_pkg
`default_nettype none

// Requests carry pattern bytes (tuser bit 0 low) or text bytes (tuser bit 0 high);
// tuser bit 1 starts a new pattern or text, tlast marks the final text byte. Each
// pattern byte up to PATTERN_MAX extends the prefix-function table and each text
// byte advances the match; one result per search gives the start of the first
// match or not-found on the last byte. The pattern and prefix tables sit in two
// memories with a registered read, and every fallback step of the match is one
// read of them. A text byte goes to ST_WALK, a pattern byte to ST_SEED then ST_WALK
// (the first is written from idle), and a text byte after a finished search is
// dropped in idle. Fallbacks amortize to at most one per text byte over a run. A
// result waits in an output register while the next request is taken.

module kmp_substring_search_top #(
   parameter int              PATTERN_MAX = 16,
   parameter longint unsigned TEXT_MAX    = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // data_byte
   input  wire logic [1:0]  req_tuser,  // opcode, first
   input  wire logic        req_tlast,  // last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,  // match_start
   output logic      [0:0]  rsp_tuser   // found
);
   import kss_pkg::*;

   localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LW = $clog2(PATTERN_MAX + 1);

   kss_result_type    res;
   logic              out_free;
   logic              wr_en;
   logic [IW-1:0]     wr_addr, wr_prefix, st_rd_addr, pf_rd_addr, pf_rd_data;
   logic [DATA_W-1:0] wr_byte, st_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]  rsp_start_ff, rsp_start_in;

   kss_tables #(
      .DEPTH (PATTERN_MAX),
      .IW    (IW)
   ) u_tables (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_byte    (wr_byte),
      .wr_prefix  (wr_prefix),
      .st_rd_addr (st_rd_addr),
      .pf_rd_addr (pf_rd_addr),
      .st_rd_data (st_rd_data),
      .pf_rd_data (pf_rd_data)
   );

   kss_ctrl #(
      .PATTERN_MAX (PATTERN_MAX),
      .TEXT_MAX    (TEXT_MAX),
      .IW          (IW),
      .LW          (LW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_opcode (req_tuser[0]),
      .req_first  (req_tuser[1]),
      .req_last   (req_tlast),
      .req_data   (req_tdata),
      .out_free   (out_free),
      .res        (res),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_byte    (wr_byte),
      .wr_prefix  (wr_prefix),
      .st_rd_addr (st_rd_addr),
      .pf_rd_addr (pf_rd_addr),
      .st_rd_data (st_rd_data),
      .pf_rd_data (pf_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = res.found;
         rsp_start_in = res.start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_start_ff;
   assign rsp_tuser[0] = rsp_found_ff;

endmodule

`default_nettype wire

/* sv/kss_checker.sv */
// kss_checker: port-level assertions for kmp_substring_search_top
// bound to the top level at the end of this file
`default_nettype none

module kss_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // not-found carries a zero position
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 16'd0)
      else $error("not-found with nonzero position");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a result never comes in the cycle right after a request is taken
   a_no_same_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result too soon after request");

endmodule

bind kmp_substring_search_top kss_checker u_kss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* tb/tb.sv */
// tb: self-checking testbench for kmp_substring_search_top, pattern load and text search
// keeps its own prefix-function search state to predict each match or not-found result
// depends on kss_pkg and kmp_substring_search_top
`default_nettype none

module tb;
   import kss_pkg::*;

   localparam int PAT_DEPTH   = 16;
   localparam logic [15:0] POS_LIMIT = 16'hFFFF;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int RAND_ITEMS  = 600;

   typedef struct packed {
      logic        found;
      logic [15:0] start;
   } match_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;  // data_byte
   logic [1:0]  req_tuser  = 2'b00;  // opcode, first
   logic        req_tlast  = 1'b0;   // last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // match_start
   logic [0:0]  rsp_tuser;           // found

   // search state mirrored for prediction
   logic [7:0]  pat_mem [PAT_DEPTH];
   logic [4:0]  fail_len[PAT_DEPTH];
   logic [4:0]  pat_len     = '0;
   logic [4:0]  run_len     = '0;
   logic [15:0] text_pos    = '0;
   logic        search_over = 1'b0;

   match_type expected_matches[$];
   int     error_count  = 0;
   int     bytes_sent   = 0;
   int     idle_cycles  = 0;
   bit     idle_on      = 1'b1;
   bit     hold_go      = 1'b0;

   kmp_substring_search_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic post_match(input logic fnd, input logic [15:0] st);
      match_type r;
      r.found = fnd;
      r.start = st;
      expected_matches.push_back(r);
   endtask

   task automatic advance_search(input logic op, input logic [7:0] b, input logic fst,
                                 input logic lst);
      logic [4:0]  i;
      logic [4:0]  k;
      logic [4:0]  m;
      logic [15:0] pos;
      logic [15:0] back;
      if (op == OP_PATTERN) begin
         if (fst) pat_len = '0;
         run_len = '0;
         text_pos = '0;
         search_over = 1'b0;
         if (pat_len < PAT_DEPTH) begin
            i = pat_len;
            pat_mem[i[3:0]] = b;
            k = '0;
            if (i > 0) begin
               k = fail_len[4'(i - 5'd1)];
               while (k > 0 && pat_mem[k[3:0]] != b) k = fail_len[4'(k - 5'd1)];
               if (k < i && pat_mem[k[3:0]] == b) k++;
            end
            fail_len[i[3:0]] = k;
            pat_len = i + 5'd1;
         end
         return;
      end
      if (fst) begin
         run_len = '0;
         text_pos = '0;
         search_over = 1'b0;
      end
      if (search_over) return;
      pos = text_pos;
      if (text_pos < POS_LIMIT) text_pos++;
      if (pat_len == 0) begin
         search_over = 1'b1;
         post_match(1'b1, 16'd0);
         return;
      end
      m = run_len;
      if (m >= pat_len) m = '0;
      while (m > 0 && pat_mem[m[3:0]] != b) m = fail_len[4'(m - 5'd1)];
      if (pat_mem[m[3:0]] == b) m++;
      run_len = m;
      if (m == pat_len) begin
         back = 16'(pat_len - 1);
         search_over = 1'b1;
         post_match(1'b1, (pos >= back) ? pos - back : 16'd0);
      end else if (lst) begin
         search_over = 1'b1;
         post_match(1'b0, 16'd0);
      end
   endtask

   task automatic send_byte(input logic op, input logic [7:0] b, input logic fst,
                            input logic lst);
      int gap;
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {fst, op};
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      advance_search(op, b, fst, lst);
      bytes_sent++;
   endtask

   // result receiver with random stalls and one long hold-off
   initial begin
      int stall;
      int hold_left;
      stall = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) stall = idle_on ? $urandom_range(0, 10) : 0;
         if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      match_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_matches.size() == 0) begin
            $error("unexpected result: found %0d match_start %0d", rsp_tuser[0], rsp_tdata);
            error_count++;
         end else begin
            want = expected_matches.pop_front();
            if (rsp_tuser[0] !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tdata !== want.start) begin
               $error("match_start: expected %0d, got %0d", want.start, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic test_empty_pattern();
      send_byte(OP_TEXT, 8'h5A, 1'b1, 1'b0);
      send_byte(OP_TEXT, 8'h00, 1'b0, 1'b1);
      send_byte(OP_TEXT, 8'hFF, 1'b1, 1'b1);
   endtask

   task automatic test_fallback_match();
      send_byte(OP_PATTERN, "a", 1'b1, 1'b1);
      send_byte(OP_PATTERN, "a", 1'b0, 1'b0);
      send_byte(OP_PATTERN, "b", 1'b0, 1'b0);
      send_byte(OP_TEXT, "x", 1'b1, 1'b0);
      send_byte(OP_TEXT, "a", 1'b0, 1'b0);
      send_byte(OP_TEXT, "a", 1'b0, 1'b0);
      send_byte(OP_TEXT, "a", 1'b0, 1'b0);
      send_byte(OP_TEXT, "b", 1'b0, 1'b1);
      send_byte(OP_TEXT, "a", 1'b0, 1'b0);
   endtask

   task automatic test_byte_extremes();
      send_byte(OP_PATTERN, 8'h00, 1'b1, 1'b0);
      send_byte(OP_PATTERN, 8'hFF, 1'b0, 1'b1);
      send_byte(OP_TEXT, 8'hFF, 1'b1, 1'b0);
      send_byte(OP_TEXT, 8'h00, 1'b0, 1'b0);
      send_byte(OP_TEXT, 8'hFF, 1'b0, 1'b1);
      send_byte(OP_TEXT, 8'h00, 1'b1, 1'b0);
      send_byte(OP_TEXT, 8'h00, 1'b0, 1'b1);
      // restart of the text in the middle of a search
      send_byte(OP_TEXT, 8'h00, 1'b1, 1'b0);
      send_byte(OP_TEXT, 8'hFF, 1'b1, 1'b0);
      send_byte(OP_TEXT, 8'hFF, 1'b0, 1'b1);
      // new pattern in the middle of a search
      send_byte(OP_TEXT, 8'h00, 1'b1, 1'b0);
      send_byte(OP_PATTERN, 8'hFF, 1'b1, 1'b0);
      send_byte(OP_TEXT, 8'hFF, 1'b0, 1'b1);
   endtask

   task automatic test_output_backpressure();
      idle_on = 1'b0;
      send_byte(OP_PATTERN, "a", 1'b1, 1'b0);
      send_byte(OP_PATTERN, "b", 1'b0, 1'b0);
      hold_go = 1'b1;
      repeat (12) begin
         send_byte(OP_TEXT, "a", 1'b1, 1'b0);
         send_byte(OP_TEXT, "b", 1'b0, 1'b1);
      end
      idle_on = 1'b1;
   endtask

   task automatic test_random_searches();
      logic [7:0] pat[20];
      logic [7:0] base;
      logic [7:0] c;
      logic       wide;
      logic       fst;
      logic       lst;
      int         plen;
      int         tlen;
      int         at;
      int         n;
      int         goal;
      bit         first_round;
      goal = bytes_sent + RAND_ITEMS;
      first_round = 1'b1;
      plen = 0;
      base = 8'h00;
      wide = 1'b0;
      while (bytes_sent < goal) begin
         idle_on = ($urandom_range(0, 9) != 0);
         if (!first_round && $urandom_range(0, 6) == 0) begin
            send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            if (first_round || plen == 0 || $urandom_range(0, 2) == 0) begin
               base = 8'($urandom_range(0, 255));
               wide = ($urandom_range(0, 3) == 0);
               if (first_round) plen = 18;
               else if ($urandom_range(0, 7) == 0) plen = $urandom_range(9, 20);
               else plen = $urandom_range(1, 8);
               for (n = 0; n < plen; n++) begin
                  pat[n] = wide ? 8'($urandom_range(0, 255)) : base + 8'($urandom_range(0, 1));
                  fst = (n == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0);
                  send_byte(OP_PATTERN, pat[n], fst, 1'($urandom_range(0, 1)));
               end
               first_round = 1'b0;
            end
            tlen = $urandom_range(1, 24);
            at = $urandom_range(0, 1) ? int'($urandom_range(0, tlen - 1)) : -1;
            for (n = 0; n < tlen; n++) begin
               if (at >= 0 && n >= at && n - at < plen) c = pat[n - at];
               else c = wide ? 8'($urandom_range(0, 255)) : base + 8'($urandom_range(0, 1));
               fst = (n == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 31) == 0);
               lst = (n == tlen - 1) ? ($urandom_range(0, 9) != 0)
                                     : ($urandom_range(0, 31) == 0);
               send_byte(OP_TEXT, c, fst, lst);
            end
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_pattern();
      test_fallback_match();
      test_byte_extremes();
      test_output_backpressure();
      test_random_searches();
      req_tvalid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
